// File: hdl/mcwk_pkg.sv
// ---------------------------------------------------------------------------
// mcwk_pkg - shared definitions of the multiplexed clock with keys
// Time type, reset values, key bits and the digit and segment helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package mcwk_pkg;

  localparam int unsigned TpsW     = 16;
  localparam int unsigned DigitN   = 6;
  localparam int unsigned PosW     = 3;
  localparam int unsigned SegW     = 7;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [TpsW-1:0] TpsReset = 16'd1152;

  localparam logic [ApbAddrW-1:0] RegTicksPerSecond = 3'd0;

  // scan positions and key word bits
  localparam logic [PosW-1:0] PosEval = 3'd4;
  localparam logic [PosW-1:0] PosLast = 3'd5;
  localparam int unsigned KeyLeft  = 5;
  localparam int unsigned KeyDown  = 4;
  localparam int unsigned KeyRight = 2;

  localparam logic [HourW-1:0] HourReset = 5'd23;
  localparam logic [MinW-1:0]  MinReset  = 6'd58;
  localparam logic [SecW-1:0]  SecReset  = 6'd45;
  localparam logic [HourW-1:0] HourMax   = 5'd23;
  localparam logic [MinW-1:0]  MinMax    = 6'd59;
  localparam logic [SecW-1:0]  SecMax    = 6'd59;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  min;
    logic [SecW-1:0]  sec;
  } time_t;

  function automatic time_t inc_hour(time_t t);
    time_t r;
    r = t;
    r.hour = (t.hour == HourMax) ? '0 : t.hour + 5'd1;
    return r;
  endfunction

  function automatic time_t inc_min(time_t t);
    time_t r;
    r = t;
    if (t.min == MinMax) begin
      r.min = '0;
      r.hour = (t.hour == HourMax) ? '0 : t.hour + 5'd1;
    end else begin
      r.min = t.min + 6'd1;
    end
    return r;
  endfunction

  function automatic time_t inc_sec(time_t t);
    time_t r;
    r = t;
    if (t.sec == SecMax) begin
      r = inc_min(t);
      r.sec = '0;
    end else begin
      r.sec = t.sec + 6'd1;
    end
    return r;
  endfunction

  // tens digit of a value below 64
  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [3:0] d;
    if (v >= 6'd60)      d = 4'd6;
    else if (v >= 6'd50) d = 4'd5;
    else if (v >= 6'd40) d = 4'd4;
    else if (v >= 6'd30) d = 4'd3;
    else if (v >= 6'd20) d = 4'd2;
    else if (v >= 6'd10) d = 4'd1;
    else                 d = 4'd0;
    return d;
  endfunction

  function automatic logic [3:0] units_of(logic [5:0] v);
    logic [5:0] t10;
    t10 = 6'(tens_of(v)) * 6'd10;
    return 4'(v - t10);
  endfunction

  // bit0 segment a .. bit6 segment g
  function automatic logic [SegW-1:0] seg_of(logic [3:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mcwk_if.sv
// ---------------------------------------------------------------------------
// mcwk_in_if / mcwk_out_if - request channels of the clock block
// Valid/ready channels for scan ticks in and display results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface mcwk_in_if;
  logic valid;
  logic ready;
  logic key_sense;

  modport source (output valid, output key_sense, input ready);
  modport sink (input valid, input key_sense, output ready);
endinterface

interface mcwk_out_if;
  logic                         valid;
  logic                         ready;
  logic [mcwk_pkg::DigitN-1:0] digit_enable;
  logic [mcwk_pkg::SegW-1:0]   segments;
  logic                         second_led;
  logic [mcwk_pkg::HourW-1:0]  hours;
  logic [mcwk_pkg::MinW-1:0]   minutes;
  logic [mcwk_pkg::SecW-1:0]   seconds;

  modport source (
    output valid, output digit_enable, output segments, output second_led,
    output hours, output minutes, output seconds, input ready
  );
  modport sink (
    input valid, input digit_enable, input segments, input second_led,
    input hours, input minutes, input seconds, output ready
  );
endinterface

`default_nettype wire

// File: hdl/mcwk_disp.sv
// ---------------------------------------------------------------------------
// mcwk_disp - digit selection and seven-segment encoding
// Picks the decimal digit of the time for a scan position and encodes it.
// ---------------------------------------------------------------------------
`default_nettype none

module mcwk_disp (
  input  wire logic [mcwk_pkg::PosW-1:0]   pos_i,
  input  wire mcwk_pkg::time_t             time_i,
  output logic      [mcwk_pkg::DigitN-1:0] enable_o,
  output logic      [mcwk_pkg::SegW-1:0]   segs_o
);

  logic [3:0] digit;

  always_comb begin
    case (pos_i)
      3'd0:    digit = mcwk_pkg::units_of(time_i.sec);
      3'd1:    digit = mcwk_pkg::tens_of(time_i.sec);
      3'd2:    digit = mcwk_pkg::units_of(time_i.min);
      3'd3:    digit = mcwk_pkg::tens_of(time_i.min);
      3'd4:    digit = mcwk_pkg::units_of({1'b0, time_i.hour});
      default: digit = mcwk_pkg::tens_of({1'b0, time_i.hour});
    endcase
  end

  assign enable_o = mcwk_pkg::DigitN'(1) << pos_i;
  assign segs_o   = mcwk_pkg::seg_of(digit);

endmodule

`default_nettype wire

// File: hdl/multiplexed_clock_with_keys_core.sv
// ---------------------------------------------------------------------------
// multiplexed_clock_with_keys_core - six-digit multiplexed clock with keys
// Time of day, digit scan, key handling and one-second divider.
// ---------------------------------------------------------------------------
// Each scan tick request drives one digit (seconds units first, hours tens
// last) with the time as it stood before the tick and ORs the key line into
// the current frame; keys are evaluated with the hours units digit. The
// block takes one tick per clock cycle while its results are taken: a tick
// sits in an input register, the whole state update for it is combinational
// and the result lands in an output register. A stalled result holds the
// tick behind it. The APB register ticks_per_second (byte address 0, reset
// 1152) reloads the divider; a write takes effect at the next reload.
// ---------------------------------------------------------------------------
`default_nettype none

module multiplexed_clock_with_keys_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  mcwk_in_if.sink                                in_i,
  mcwk_out_if.source                             res_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mcwk_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [mcwk_pkg::ApbDataW-1:0]     pwdata,
  output logic      [mcwk_pkg::ApbDataW-1:0]     prdata,
  output logic                                   pready
);

  // configuration
  logic [mcwk_pkg::TpsW-1:0] tps_q;
  logic                      reg_sel;
  logic                      cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[mcwk_pkg::ApbAddrW-1:2] ==
                   mcwk_pkg::RegTicksPerSecond[mcwk_pkg::ApbAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? mcwk_pkg::ApbDataW'(tps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= mcwk_pkg::TpsReset;
    end else if (cfg_wr) begin
      tps_q <= pwdata[mcwk_pkg::TpsW-1:0];
    end
  end

  // input register
  logic in_vld_q;
  logic key_q;
  logic fire;

  assign fire     = in_vld_q && (!res_o.valid || res_o.ready);
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      key_q <= in_i.key_sense;
    end
  end

  // clock state
  mcwk_pkg::time_t               time_q, time_d, time_key;
  logic [mcwk_pkg::PosW-1:0]     pos_q, pos_d;
  logic [mcwk_pkg::DigitN-1:0]   kw_q, kw_d, kw_now;
  logic [mcwk_pkg::DigitN-1:0]   hist_q [3];
  logic [mcwk_pkg::DigitN-1:0]   hist_d [3];
  logic [mcwk_pkg::TpsW-1:0]     tick_q, tick_d, tick_dec;
  logic                          led_q, led_d;
  logic [mcwk_pkg::DigitN-1:0]   enable;
  logic [mcwk_pkg::SegW-1:0]     segs;
  logic                          eval, fresh, expire;

  mcwk_disp u_disp (
    .pos_i    (pos_q),
    .time_i   (time_q),
    .enable_o (enable),
    .segs_o   (segs)
  );

  always_comb begin
    kw_now = key_q ? (kw_q | enable) : kw_q;
    eval   = (pos_q == mcwk_pkg::PosEval);
    fresh  = (kw_now != '0) && (kw_now != hist_q[0]) &&
             (kw_now != hist_q[1]) && (kw_now != hist_q[2]);

    time_key = time_q;
    if (eval && fresh) begin
      if (kw_now[mcwk_pkg::KeyLeft]) begin
        time_key = mcwk_pkg::inc_hour(time_q);
      end else if (kw_now[mcwk_pkg::KeyDown]) begin
        time_key = mcwk_pkg::inc_min(time_q);
      end else if (kw_now[mcwk_pkg::KeyRight]) begin
        time_key = mcwk_pkg::inc_sec(time_q);
      end
    end

    hist_d = hist_q;
    kw_d   = kw_now;
    if (eval) begin
      kw_d = '0;
      if (kw_now == '0) begin
        hist_d[0] = '0;
        hist_d[1] = '0;
        hist_d[2] = '0;
      end else begin
        hist_d[2] = hist_q[1];
        hist_d[1] = hist_q[0];
        hist_d[0] = kw_now;
      end
    end

    pos_d = (pos_q == mcwk_pkg::PosLast) ? '0 : pos_q + 3'd1;

    // divider wraps modulo 2^16, a zero reload means 65536 ticks
    tick_dec = tick_q - 16'd1;
    expire   = (tick_dec == '0);
    tick_d   = expire ? tps_q : tick_dec;
    led_d    = led_q ^ expire;
    time_d   = expire ? mcwk_pkg::inc_sec(time_key) : time_key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q.hour <= mcwk_pkg::HourReset;
      time_q.min  <= mcwk_pkg::MinReset;
      time_q.sec  <= mcwk_pkg::SecReset;
      pos_q       <= '0;
      kw_q        <= '0;
      hist_q[0]   <= '0;
      hist_q[1]   <= '0;
      hist_q[2]   <= '0;
      tick_q      <= mcwk_pkg::TpsReset;
      led_q       <= 1'b0;
    end else if (fire) begin
      time_q <= time_d;
      pos_q  <= pos_d;
      kw_q   <= kw_d;
      hist_q <= hist_d;
      tick_q <= tick_d;
      led_q  <= led_d;
    end
  end

  // result register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_o.digit_enable <= enable;
      res_o.segments     <= segs;
      res_o.second_led   <= led_d;
      res_o.hours        <= time_d.hour;
      res_o.minutes      <= time_d.min;
      res_o.seconds      <= time_d.sec;
    end
  end

  assign res_o.valid = out_vld_q;

  // checks
  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> $onehot(res_o.digit_enable))
    else $error("digit enable not one-hot");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.hour <= mcwk_pkg::HourMax) && (time_q.min <= mcwk_pkg::MinMax) &&
    (time_q.sec <= mcwk_pkg::SecMax) && (pos_q <= mcwk_pkg::PosLast))
    else $error("time or scan position out of range");

  a_led_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (tick_q == 16'd1)) |=> (led_q != $past(led_q)))
    else $error("led did not toggle on divider expiry");

  a_key_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (pos_q == mcwk_pkg::PosEval)) |=> (kw_q == '0))
    else $error("key word not cleared after evaluation");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_o.hours) &&
                                      $stable(res_o.digit_enable)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// File: verif/multiplexed_clock_with_keys_core_tb.sv
// ---------------------------------------------------------------------------
// multiplexed_clock_with_keys_core_tb - scan, key and divider checks
// Drives scan tick requests with random key sense and random gaps on both
// channels. A local model of the clock predicts every display request, and
// each one is checked field by field as it leaves the block. The tick rate
// register is rewritten between phases, covering its extremes.
// ---------------------------------------------------------------------------
`default_nettype none

module multiplexed_clock_with_keys_core_tb;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [mcwk_pkg::DigitN-1:0] digit_enable;
    logic [mcwk_pkg::SegW-1:0]   segments;
    logic                        second_led;
    logic [mcwk_pkg::HourW-1:0]  hours;
    logic [mcwk_pkg::MinW-1:0]   minutes;
    logic [mcwk_pkg::SecW-1:0]   seconds;
  } display_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [mcwk_pkg::ApbAddrW-1:0] paddr = '0;
  logic [mcwk_pkg::ApbDataW-1:0] pwdata = '0;
  logic [mcwk_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  mcwk_in_if  in_if ();
  mcwk_out_if res_if ();

  multiplexed_clock_with_keys_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // clock model
  logic [mcwk_pkg::HourW-1:0]  now_hour;
  logic [mcwk_pkg::MinW-1:0]   now_min;
  logic [mcwk_pkg::SecW-1:0]   now_sec;
  logic [mcwk_pkg::PosW-1:0]   digit_pos;
  logic [mcwk_pkg::DigitN-1:0] frame_keys;
  logic [mcwk_pkg::DigitN-1:0] key_hist0, key_hist1, key_hist2;
  logic [mcwk_pkg::TpsW-1:0]   div_left;
  logic [mcwk_pkg::TpsW-1:0]   div_reload;
  logic                        led_state;

  logic     key_ticks [$];
  display_t display_due [$];
  int       ticks_queued = 0;
  int       ticks_taken = 0;
  int       faults = 0;
  int       cycle_count = 0;

  task automatic bump_hour();
    now_hour = (now_hour == mcwk_pkg::HourW'(23)) ? '0 : now_hour + 1'b1;
  endtask

  task automatic bump_minute();
    if (now_min == mcwk_pkg::MinW'(59)) begin
      now_min = '0;
      bump_hour();
    end else begin
      now_min = now_min + 1'b1;
    end
  endtask

  task automatic bump_second();
    if (now_sec == mcwk_pkg::SecW'(59)) begin
      now_sec = '0;
      bump_minute();
    end else begin
      now_sec = now_sec + 1'b1;
    end
  endtask

  // one scan tick: show the digit, sense the key, evaluate, run the divider
  task automatic scan_tick(input logic pressed);
    display_t d;
    int digit;
    d.digit_enable = mcwk_pkg::DigitN'(1) << digit_pos;
    case (digit_pos)
      3'd0:    digit = now_sec % 10;
      3'd1:    digit = now_sec / 10;
      3'd2:    digit = now_min % 10;
      3'd3:    digit = now_min / 10;
      3'd4:    digit = now_hour % 10;
      default: digit = now_hour / 10;
    endcase
    case (digit)
      0:       d.segments = 7'h3F;
      1:       d.segments = 7'h06;
      2:       d.segments = 7'h5B;
      3:       d.segments = 7'h4F;
      4:       d.segments = 7'h66;
      5:       d.segments = 7'h6D;
      6:       d.segments = 7'h7D;
      7:       d.segments = 7'h07;
      8:       d.segments = 7'h7F;
      default: d.segments = 7'h6F;
    endcase
    if (pressed) frame_keys = frame_keys | d.digit_enable;
    if (digit_pos == mcwk_pkg::PosEval) begin
      if (frame_keys == '0) begin
        key_hist0 = '0;
        key_hist1 = '0;
        key_hist2 = '0;
      end else begin
        // a word already seen in the last three frames is a held key
        if (frame_keys != key_hist0 && frame_keys != key_hist1 &&
            frame_keys != key_hist2) begin
          if (frame_keys[mcwk_pkg::KeyLeft]) bump_hour();
          else if (frame_keys[mcwk_pkg::KeyDown]) bump_minute();
          else if (frame_keys[mcwk_pkg::KeyRight]) bump_second();
        end
        key_hist2 = key_hist1;
        key_hist1 = key_hist0;
        key_hist0 = frame_keys;
        frame_keys = '0;
      end
    end
    digit_pos = (digit_pos == mcwk_pkg::PosLast) ? '0 : digit_pos + 1'b1;
    div_left = div_left - 1'b1;
    if (div_left == '0) begin
      led_state = ~led_state;
      bump_second();
      div_left = div_reload;
    end
    d.second_led = led_state;
    d.hours = now_hour;
    d.minutes = now_min;
    d.seconds = now_sec;
    display_due.push_back(d);
  endtask

  // no gaps on either side while scan ticks 400 to 649 are taken
  function automatic bit take_break();
    if (ticks_taken >= 400 && ticks_taken < 650) return 1'b0;
    return $urandom_range(0, 99) < 25;
  endfunction

  task automatic push_frame(input logic [mcwk_pkg::DigitN-1:0] keys);
    for (int i = 0; i < mcwk_pkg::DigitN; i++) begin
      key_ticks.push_back(keys[i]);
      ticks_queued++;
    end
  endtask

  // mostly single presses, held keys and idle frames; some full noise and broken frames
  task automatic queue_random_frames(input int frames);
    logic [mcwk_pkg::DigitN-1:0] held;
    logic [mcwk_pkg::DigitN-1:0] keys;
    int extra;
    held = '0;
    for (int f = 0; f < frames; f++) begin
      case ($urandom_range(0, 9))
        0, 1: keys = '0;
        2, 3: begin
          case ($urandom_range(0, 3))
            0:       keys = mcwk_pkg::DigitN'(1) << mcwk_pkg::KeyLeft;
            1:       keys = mcwk_pkg::DigitN'(1) << mcwk_pkg::KeyDown;
            2:       keys = mcwk_pkg::DigitN'(1) << mcwk_pkg::KeyRight;
            default: keys = mcwk_pkg::DigitN'(1);
          endcase
        end
        4, 5, 6: keys = held;
        7, 8: keys = mcwk_pkg::DigitN'($urandom);
        default: begin
          // broken frame: a few stray ticks shift the scan alignment
          keys = mcwk_pkg::DigitN'($urandom);
          extra = $urandom_range(1, 5);
          for (int i = 0; i < extra; i++) begin
            key_ticks.push_back(1'($urandom));
            ticks_queued++;
          end
        end
      endcase
      push_frame(keys);
      held = keys;
    end
  endtask

  task automatic drain();
    while (ticks_taken != ticks_queued || display_due.size() != 0) @(posedge clk_i);
  endtask

  // write the tick rate register, then read it back
  task automatic set_tick_rate(input logic [mcwk_pkg::TpsW-1:0] rate);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= mcwk_pkg::RegTicksPerSecond;
    pwdata <= mcwk_pkg::ApbDataW'(rate);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    div_reload = rate;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== mcwk_pkg::ApbDataW'(rate)) begin
      faults++;
      if (faults <= 10) $display("tick rate readback: expected %0d, got %0d", rate, prdata);
    end
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // scan tick driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.key_sense <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        scan_tick(in_if.key_sense);
        ticks_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (key_ticks.size() != 0 && !take_break()) begin
          in_if.valid <= 1'b1;
          in_if.key_sense <= key_ticks.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // display request monitor
  always @(posedge clk_i) begin : monitor
    display_t got;
    display_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = {res_if.digit_enable, res_if.segments, res_if.second_led,
               res_if.hours, res_if.minutes, res_if.seconds};
        if (display_due.size() == 0) begin
          faults++;
          if (faults <= 10) $display("unexpected display request: en=%b", got.digit_enable);
        end else begin
          want = display_due.pop_front();
          if (got.digit_enable !== want.digit_enable || got.segments !== want.segments ||
              got.second_led !== want.second_led || got.hours !== want.hours ||
              got.minutes !== want.minutes || got.seconds !== want.seconds) begin
            faults++;
            if (faults <= 10)
              $display("mismatch: expected en=%b seg=%h led=%b %0d:%0d:%0d,",
                       want.digit_enable, want.segments, want.second_led,
                       want.hours, want.minutes, want.seconds,
                       " got en=%b seg=%h led=%b %0d:%0d:%0d",
                       got.digit_enable, got.segments, got.second_led,
                       got.hours, got.minutes, got.seconds);
          end
        end
      end
      res_if.ready <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [mcwk_pkg::TpsW-1:0] rates [4];
    rates[0] = mcwk_pkg::TpsW'(1);
    rates[1] = mcwk_pkg::TpsW'(9);
    rates[2] = '1;
    rates[3] = '0;
    in_if.valid = 1'b0;
    in_if.key_sense = 1'b0;
    res_if.ready = 1'b0;
    now_hour = mcwk_pkg::HourW'(23);
    now_min = mcwk_pkg::MinW'(58);
    now_sec = mcwk_pkg::SecW'(45);
    digit_pos = '0;
    frame_keys = '0;
    key_hist0 = '0;
    key_hist1 = '0;
    key_hist2 = '0;
    div_reload = mcwk_pkg::TpsReset;
    div_left = mcwk_pkg::TpsReset;
    led_state = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // divider still counts down from the reset rate; this applies at its reload
    set_tick_rate(mcwk_pkg::TpsW'(2));

    // left sensed on hours tens lands in the next frame, with down and bit 0
    push_frame(6'b100000);
    push_frame(6'b010001);
    push_frame(6'b000100);
    // same right word again is a held key, then an empty frame clears history
    push_frame(6'b000100);
    push_frame(6'b000000);

    // single presses, held keys, noise and stray ticks
    queue_random_frames(70);
    drain();

    foreach (rates[i]) begin
      set_tick_rate(rates[i]);
      queue_random_frames(i == 3 ? 8 : 12);
      drain();
    end

    repeat (10) @(posedge clk_i);
    faults += display_due.size();
    if (faults == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hdl/mcwk_pkg.sv
hdl/mcwk_if.sv
hdl/mcwk_disp.sv
hdl/multiplexed_clock_with_keys_core.sv
verif/multiplexed_clock_with_keys_core_tb.sv
